### src/swfv_pkg.sv
// Shared fixed-point types, constants and arithmetic helpers for the face velocity block.
package swfv_pkg;

  localparam int WB = 32;
  localparam int FB = 16;

  typedef logic signed [WB-1:0] q_t;

  localparam q_t Q_MAX     = 32'sh7fff_ffff;
  localparam q_t Q_MIN     = 32'sh8000_0000;
  localparam q_t Q_ONE     = 32'sh0001_0000;
  localparam q_t Q_HALF    = 32'sh0000_8000;
  localparam q_t Q_QUARTER = 32'sh0000_4000;
  localparam q_t Q_GRAV    = 32'sh0009_cf5c;

  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INV_DT  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INV_DX  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ADV     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FRIC    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FMODE   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_XUPWIND = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DTHR    = 3'd6;

  localparam logic FMODE_CHEZY = 1'b1;

  localparam logic [1:0] EDGE_FIRST = 2'd1;
  localparam logic [1:0] EDGE_LAST  = 2'd2;

  // cube root operand is h << 2*FB, taken three bits per step
  localparam int CX_BITS = WB - 1 + 2 * FB;
  localparam int CR_BITS = (CX_BITS + 2) / 3;

  function automatic logic [WB-1:0] mag(input q_t a);
    return a[WB-1] ? WB'(-a) : WB'(a);
  endfunction

  function automatic q_t from_mag(input logic neg, input logic [63:0] m);
    if (!neg) return (m > 64'(Q_MAX)) ? Q_MAX : q_t'(m[WB-1:0]);
    if (m > 64'(Q_MAX) + 64'd1) return Q_MIN;
    return q_t'(-m[WB-1:0]);
  endfunction

  function automatic q_t sat_wide(input logic [WB:0] v);
    if (v[WB] != v[WB-1]) return v[WB] ? Q_MIN : Q_MAX;
    return q_t'(v[WB-1:0]);
  endfunction

  function automatic q_t sadd(input q_t a, input q_t b);
    return sat_wide({a[WB-1], a} + {b[WB-1], b});
  endfunction

  function automatic q_t ssub(input q_t a, input q_t b);
    return sat_wide({a[WB-1], a} - {b[WB-1], b});
  endfunction

  // rounded half away from zero, saturated
  function automatic q_t mulq(input q_t a, input q_t b);
    logic [2*WB-1:0] p;
    p = {{WB{1'b0}}, mag(a)} * {{WB{1'b0}}, mag(b)};
    p = p + (2*WB)'(1 << (FB - 1));
    return from_mag(a[WB-1] ^ b[WB-1], 64'(p[2*WB-1:FB]));
  endfunction

endpackage

### src/swfv_if.sv
// Item and configuration channel interfaces for the face velocity block.
interface swfv_in_if;
  logic               valid;
  logic               ready;
  logic [30:0]        depth_here;
  logic [30:0]        depth_behind;
  logic signed [31:0] bed_here;
  logic signed [31:0] bed_behind;
  logic signed [31:0] vel_face;
  logic signed [31:0] vel_prev_face;
  logic signed [31:0] vel_next_face;
  logic signed [31:0] vel_side_lo;
  logic signed [31:0] vel_side_hi;
  logic signed [31:0] cross_sum;
  logic [1:0]         edge_pos;

  modport source (output valid, depth_here, depth_behind, bed_here, bed_behind, vel_face,
                  vel_prev_face, vel_next_face, vel_side_lo, vel_side_hi, cross_sum,
                  edge_pos, input ready);
  modport sink (input valid, depth_here, depth_behind, bed_here, bed_behind, vel_face,
                vel_prev_face, vel_next_face, vel_side_lo, vel_side_hi, cross_sum,
                edge_pos, output ready);
endinterface

interface swfv_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_vel;
  logic               keep_old;

  modport source (output valid, new_vel, keep_old, input ready);
  modport sink (input valid, new_vel, keep_old, output ready);
endinterface

interface swfv_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/shallow_water_face_velocity_top.sv
// Face velocity update: front arithmetic stages, root units, two dividers and output register.
// Throughput: one item per cycle; a stalled output freezes the whole pipeline in place.
// Path: 5 front stages, cube root 22, square root 33, 1, divider 50, 2, divider 50, output 1.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults.
module shallow_water_face_velocity_top import swfv_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  swfv_in_if.sink    in_ch,
  swfv_out_if.source out_ch,
  swfv_cfg_if.sink   cfg_ch
);

  typedef struct packed {
    logic            dry;
    logic            keep;
    q_t              hedge;
    q_t              num;
    q_t              ad;
    q_t              u;
    logic [2*WB-1:0] sq;
  } cb_side_t;

  typedef struct packed {
    logic               dry;
    logic               keep;
    q_t                 hedge;
    q_t                 num;
    q_t                 ad;
    q_t                 u;
    logic [CR_BITS-1:0] cr;
  } sq_side_t;

  typedef struct packed {
    logic dry;
    logic keep;
    q_t   num;
    q_t   ad;
    q_t   u;
    q_t   m1;
  } d1_side_t;

  typedef struct packed {
    logic dry;
    logic keep;
    q_t   u;
  } d2_side_t;

  logic        en;
  logic [30:0] inv_dt_r, inv_dx_r, adv_r, fric_r, dthr_r;
  logic        fmode_r;
  logic [16:0] xup_r;
  q_t          rdt, rdx, adv, fc, cu;

  assign rdt = q_t'({1'b0, inv_dt_r});
  assign rdx = q_t'({1'b0, inv_dx_r});
  assign adv = q_t'({1'b0, adv_r});
  assign fc  = q_t'({1'b0, fric_r});
  assign cu  = q_t'({15'b0, xup_r});

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_dt_r <= 31'd65536;
      inv_dx_r <= 31'd1311;
      adv_r    <= 31'd65536;
      fric_r   <= 31'd788;
      fmode_r  <= 1'b0;
      xup_r    <= 17'd0;
      dthr_r   <= 31'd655;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_INV_DT:  inv_dt_r <= cfg_ch.data[30:0];
        CFG_INV_DX:  inv_dx_r <= cfg_ch.data[30:0];
        CFG_ADV:     adv_r    <= cfg_ch.data[30:0];
        CFG_FRIC:    fric_r   <= cfg_ch.data[30:0];
        CFG_FMODE:   fmode_r  <= cfg_ch.data[0];
        CFG_XUPWIND: xup_r    <= cfg_ch.data[16:0];
        CFG_DTHR:    dthr_r   <= cfg_ch.data[30:0];
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  q_t   out_vel_r;
  logic out_keep_r;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 0: input item register
  logic        s0_vld_r;
  logic [30:0] s0_ha_r, s0_hb_r;
  q_t          s0_za_r, s0_zb_r, s0_u_r, s0_up_r, s0_un_r, s0_slo_r, s0_shi_r, s0_vs_r;
  logic [1:0]  s0_edge_r;

  // stage 1
  logic       s1_vld_r, s1_dry_r;
  q_t         s1_wlmax_r, s1_zmax_r, s1_dwl_r, s1_dal_r, s1_back_r, s1_fwd_r, s1_dside_r;
  q_t         s1_v4_r, s1_u_r;
  logic [1:0] s1_edge_r;

  // stage 2
  logic            s2_vld_r, s2_dry_r;
  q_t              s2_hedge_r, s2_dhdx_r, s2_dudx_r, s2_e1_r, s2_e2_r, s2_c1_r;
  q_t              s2_ab_r, s2_bf_r, s2_hr_r, s2_ut_r, s2_av_r, s2_u_r;
  logic [2*WB-1:0] s2_usq_r, s2_vsq_r;
  logic [1:0]      s2_edge_r;

  // stage 3
  logic            s3_vld_r, s3_dry_r;
  q_t              s3_hedge_r, s3_dudy_r, s3_gd_r, s3_ad_r, s3_ut_r, s3_av_r, s3_u_r;
  logic [2*WB-1:0] s3_sq_r;

  // stage 4
  logic            s4_vld_r, s4_dry_r;
  q_t              s4_hedge_r, s4_t_r, s4_gd_r, s4_ad_r, s4_ut_r, s4_u_r;
  logic [2*WB-1:0] s4_sq_r;

  q_t wla, wlb, up, dn, cen, bl, dudy;

  assign wla = sadd(q_t'({1'b0, s0_ha_r}), s0_za_r);
  assign wlb = sadd(q_t'({1'b0, s0_hb_r}), s0_zb_r);
  assign up  = sadd(Q_ONE, cu);
  assign dn  = ssub(Q_ONE, cu);
  assign cen = mulq(s2_c1_r, rdx);
  assign bl  = mulq(s2_hr_r, sadd(s2_ab_r, s2_bf_r));

  always_comb begin
    case (s2_edge_r)
      EDGE_FIRST: dudy = s2_e1_r;
      EDGE_LAST:  dudy = s2_e2_r;
      default:    dudy = (xup_r == '0) ? cen : bl;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
      s1_vld_r <= s0_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_ha_r   <= in_ch.depth_here;
      s0_hb_r   <= in_ch.depth_behind;
      s0_za_r   <= in_ch.bed_here;
      s0_zb_r   <= in_ch.bed_behind;
      s0_u_r    <= in_ch.vel_face;
      s0_up_r   <= in_ch.vel_prev_face;
      s0_un_r   <= in_ch.vel_next_face;
      s0_slo_r  <= in_ch.vel_side_lo;
      s0_shi_r  <= in_ch.vel_side_hi;
      s0_vs_r   <= in_ch.cross_sum;
      s0_edge_r <= in_ch.edge_pos;

      s1_dry_r   <= (s0_ha_r < dthr_r) && (s0_hb_r < dthr_r);
      s1_wlmax_r <= (wla > wlb) ? wla : wlb;
      s1_zmax_r  <= (s0_za_r > s0_zb_r) ? s0_za_r : s0_zb_r;
      s1_dwl_r   <= ssub(wla, wlb);
      s1_dal_r   <= s0_u_r[WB-1] ? ssub(s0_un_r, s0_u_r) : ssub(s0_u_r, s0_up_r);
      s1_back_r  <= ssub(s0_u_r, s0_slo_r);
      s1_fwd_r   <= ssub(s0_shi_r, s0_u_r);
      s1_dside_r <= ssub(s0_shi_r, s0_slo_r);
      s1_v4_r    <= mulq(s0_vs_r, Q_QUARTER);
      s1_u_r     <= s0_u_r;
      s1_edge_r  <= s0_edge_r;

      s2_dry_r   <= s1_dry_r;
      s2_hedge_r <= ssub(s1_wlmax_r, s1_zmax_r);
      s2_dhdx_r  <= mulq(s1_dwl_r, rdx);
      s2_dudx_r  <= mulq(s1_dal_r, rdx);
      s2_e1_r    <= mulq(s1_fwd_r, rdx);
      s2_e2_r    <= mulq(s1_back_r, rdx);
      s2_c1_r    <= mulq(s1_dside_r, Q_HALF);
      // positive cross flow weights the backward difference by 1 + blend
      if (!s1_v4_r[WB-1] && (s1_v4_r != '0)) begin
        s2_ab_r <= mulq(up, s1_back_r);
        s2_bf_r <= mulq(dn, s1_fwd_r);
      end else begin
        s2_ab_r <= mulq(dn, s1_back_r);
        s2_bf_r <= mulq(up, s1_fwd_r);
      end
      s2_hr_r    <= mulq(Q_HALF, rdx);
      s2_ut_r    <= mulq(s1_u_r, rdt);
      s2_av_r    <= mulq(adv, s1_v4_r);
      s2_usq_r   <= {{WB{1'b0}}, mag(s1_u_r)} * {{WB{1'b0}}, mag(s1_u_r)};
      s2_vsq_r   <= {{WB{1'b0}}, mag(s1_v4_r)} * {{WB{1'b0}}, mag(s1_v4_r)};
      s2_u_r     <= s1_u_r;
      s2_edge_r  <= s1_edge_r;

      s3_dry_r   <= s2_dry_r;
      s3_hedge_r <= s2_hedge_r;
      s3_dudy_r  <= dudy;
      s3_gd_r    <= mulq(Q_GRAV, s2_dhdx_r);
      s3_ad_r    <= mulq(adv, s2_dudx_r);
      s3_ut_r    <= s2_ut_r;
      s3_av_r    <= s2_av_r;
      s3_sq_r    <= s2_usq_r + s2_vsq_r;
      s3_u_r     <= s2_u_r;

      s4_dry_r   <= s3_dry_r;
      s4_hedge_r <= s3_hedge_r;
      s4_t_r     <= mulq(s3_av_r, s3_dudy_r);
      s4_gd_r    <= s3_gd_r;
      s4_ad_r    <= s3_ad_r;
      s4_ut_r    <= s3_ut_r;
      s4_sq_r    <= s3_sq_r;
      s4_u_r     <= s3_u_r;
    end
  end

  cb_side_t           cb_in_side, cb_out_side;
  logic               cb_out_valid;
  logic [CR_BITS-1:0] cb_root;

  always_comb begin
    cb_in_side.dry   = s4_dry_r;
    cb_in_side.keep  = s4_hedge_r[WB-1] || (s4_hedge_r == '0);
    cb_in_side.hedge = s4_hedge_r;
    cb_in_side.num   = ssub(ssub(s4_ut_r, s4_t_r), s4_gd_r);
    cb_in_side.ad    = s4_ad_r;
    cb_in_side.u     = s4_u_r;
    cb_in_side.sq    = s4_sq_r;
  end

  swfv_cbrt #(.SW($bits(cb_side_t))) u_cbrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s4_vld_r),
    .h         (s4_hedge_r[WB-2:0]),
    .in_side   (cb_in_side),
    .out_valid (cb_out_valid),
    .root      (cb_root),
    .out_side  (cb_out_side)
  );

  sq_side_t      sq_in_side, sq_out_side;
  logic          sq_out_valid;
  logic [WB-1:0] sq_root;

  always_comb begin
    sq_in_side.dry   = cb_out_side.dry;
    sq_in_side.keep  = cb_out_side.keep;
    sq_in_side.hedge = cb_out_side.hedge;
    sq_in_side.num   = cb_out_side.num;
    sq_in_side.ad    = cb_out_side.ad;
    sq_in_side.u     = cb_out_side.u;
    sq_in_side.cr    = cb_root;
  end

  swfv_sqrt #(.SW($bits(sq_side_t))) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (cb_out_valid),
    .x         (cb_out_side.sq),
    .in_side   (sq_in_side),
    .out_valid (sq_out_valid),
    .root      (sq_root),
    .out_side  (sq_out_side)
  );

  // stage 6: friction divisor and coefficient times speed
  logic     s6_vld_r;
  q_t       s6_dd_r;
  d1_side_t s6_side_r;
  q_t       vmag, hm;

  assign vmag = sq_root[WB-1] ? Q_MAX : q_t'(sq_root);
  assign hm   = mulq(sq_out_side.hedge, q_t'({{(WB-CR_BITS){1'b0}}, sq_out_side.cr}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= sq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_dd_r        <= (fmode_r == FMODE_CHEZY) ? sq_out_side.hedge : hm;
      s6_side_r.dry  <= sq_out_side.dry;
      s6_side_r.keep <= sq_out_side.keep;
      s6_side_r.num  <= sq_out_side.num;
      s6_side_r.ad   <= sq_out_side.ad;
      s6_side_r.u    <= sq_out_side.u;
      s6_side_r.m1   <= mulq(fc, vmag);
    end
  end

  d1_side_t d1_out_side;
  logic     d1_out_valid;
  q_t       d1_fr;

  swfv_div #(.SW($bits(d1_side_t))) u_div_fric (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s6_vld_r),
    .num       (Q_ONE),
    .den       (s6_dd_r),
    .in_side   (s6_side_r),
    .out_valid (d1_out_valid),
    .quot      (d1_fr),
    .out_side  (d1_out_side)
  );

  // stages 7 and 8: friction term, then denominator
  logic     s7_vld_r, s8_vld_r;
  q_t       s7_f_r, s7_num_r, s7_ad_r, s8_num_r, s8_den_r;
  d2_side_t s7_side_r, s8_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= d1_out_valid;
      s8_vld_r <= s7_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_f_r         <= mulq(d1_out_side.m1, d1_fr);
      s7_num_r       <= d1_out_side.num;
      s7_ad_r        <= d1_out_side.ad;
      s7_side_r.dry  <= d1_out_side.dry;
      s7_side_r.keep <= d1_out_side.keep;
      s7_side_r.u    <= d1_out_side.u;

      s8_num_r  <= s7_num_r;
      s8_den_r  <= sadd(sadd(rdt, s7_f_r), s7_ad_r);
      s8_side_r <= s7_side_r;
    end
  end

  d2_side_t d2_out_side;
  logic     d2_out_valid;
  q_t       d2_res;

  swfv_div #(.SW($bits(d2_side_t))) u_div_vel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s8_vld_r),
    .num       (s8_num_r),
    .den       (s8_den_r),
    .in_side   (s8_side_r),
    .out_valid (d2_out_valid),
    .quot      (d2_res),
    .out_side  (d2_out_side)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d2_out_valid;
    end
  end

  // dry face wins over a non-positive edge depth
  always_ff @(posedge clk) begin
    if (en) begin
      if (d2_out_side.dry) begin
        out_vel_r  <= '0;
        out_keep_r <= 1'b0;
      end else if (d2_out_side.keep) begin
        out_vel_r  <= d2_out_side.u;
        out_keep_r <= 1'b1;
      end else begin
        out_vel_r  <= d2_res;
        out_keep_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.new_vel  = out_vel_r;
  assign out_ch.keep_old = out_keep_r;

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("item taken while output stalled");

  a_stall_freezes_div: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !en |=> $stable(d2_out_valid) && $stable(d2_res))
    else $error("divider advanced during stall");

  a_stall_freezes_roots: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !en |=> $stable(sq_out_valid) && $stable(cb_out_valid))
    else $error("root units advanced during stall");
`endif

endmodule

### src/swfv_cbrt.sv
// Pipelined floor cube root of h * 2^(2*FB), one result bit per stage.
module swfv_cbrt import swfv_pkg::*; #(
  parameter int SW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [WB-2:0]      h,
  input  logic [SW-1:0]      in_side,
  output logic               out_valid,
  output logic [CR_BITS-1:0] root,
  output logic [SW-1:0]      out_side
);

  localparam int RB = 3 * CR_BITS - 15;

  typedef struct packed {
    logic [CX_BITS-1:0] x;
    logic [CR_BITS-1:0] y;
    logic [RB-1:0]      r;
  } cst_t;

  function automatic cst_t cb_step(input cst_t s);
    cst_t                 n;
    logic [2:0]           g;
    logic [CR_BITS-1:0]   y2;
    logic [2*CR_BITS:0]   p;
    logic [RB-1:0]        b;
    logic [RB-1:0]        r2;
    g  = s.x[CX_BITS-1 -: 3];
    y2 = {s.y[CR_BITS-2:0], 1'b0};
    p  = {{(CR_BITS+1){1'b0}}, y2} * {{CR_BITS{1'b0}}, {1'b0, y2} + (CR_BITS+1)'(1)};
    b  = RB'({p, 1'b0}) + RB'(p) + RB'(1);
    r2 = {s.r[RB-4:0], g};
    n.x = s.x << 3;
    if (r2 >= b) begin
      n.r = r2 - b;
      n.y = y2 | CR_BITS'(1);
    end else begin
      n.r = r2;
      n.y = y2;
    end
    return n;
  endfunction

  cst_t              st_r   [0:CR_BITS];
  logic [SW-1:0]     side_r [0:CR_BITS];
  logic [CR_BITS:0]  vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[CR_BITS-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= '{x: {h, {(2*FB){1'b0}}}, y: '0, r: '0};
      side_r[0] <= in_side;
      for (int k = 1; k <= CR_BITS; k++) begin
        st_r[k]   <= cb_step(st_r[k-1]);
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[CR_BITS];
  assign root      = st_r[CR_BITS].y;
  assign out_side  = side_r[CR_BITS];

endmodule

### src/swfv_sqrt.sv
// Pipelined floor square root of a 2*WB-bit value, one result bit per stage.
module swfv_sqrt import swfv_pkg::*; #(
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*WB-1:0] x,
  input  logic [SW-1:0]   in_side,
  output logic            out_valid,
  output logic [WB-1:0]   root,
  output logic [SW-1:0]   out_side
);

  typedef struct packed {
    logic [2*WB-1:0] x;
    logic [WB+1:0]   rem;
    logic [WB-1:0]   root;
  } sst_t;

  function automatic sst_t sq_step(input sst_t s);
    sst_t          n;
    logic [WB+1:0] rem2;
    logic [WB+1:0] trial;
    rem2  = {s.rem[WB-1:0], s.x[2*WB-1 -: 2]};
    trial = {s.root, 2'b01};
    n.x   = s.x << 2;
    if (rem2 >= trial) begin
      n.rem  = rem2 - trial;
      n.root = {s.root[WB-2:0], 1'b1};
    end else begin
      n.rem  = rem2;
      n.root = {s.root[WB-2:0], 1'b0};
    end
    return n;
  endfunction

  sst_t           st_r   [0:WB];
  logic [SW-1:0]  side_r [0:WB];
  logic [WB:0]    vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[WB-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= '{x: x, rem: '0, root: '0};
      side_r[0] <= in_side;
      for (int k = 1; k <= WB; k++) begin
        st_r[k]   <= sq_step(st_r[k-1]);
        side_r[k] <= side_r[k-1];
      end
    end
  end

  assign out_valid = vld_r[WB];
  assign root      = st_r[WB].root;
  assign out_side  = side_r[WB];

endmodule

### src/swfv_div.sv
// Pipelined fixed-point divider, rounded to nearest and saturated, one quotient bit per stage.
module swfv_div import swfv_pkg::*; #(
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  q_t            num,
  input  q_t            den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output q_t            quot,
  output logic [SW-1:0] out_side
);

  localparam int NB = WB + FB;

  typedef struct packed {
    logic [WB-1:0] rem;
    logic [NB-1:0] nq;
    logic [WB-1:0] md;
    logic          neg;
    logic          dz;
    q_t            spec;
  } dst_t;

  function automatic dst_t dv_step(input dst_t s);
    dst_t        n;
    logic [WB:0] rs;
    logic [WB:0] df;
    logic        ge;
    rs = {s.rem, s.nq[NB-1]};
    df = rs - {1'b0, s.md};
    ge = rs >= {1'b0, s.md};
    n       = s;
    n.rem   = ge ? df[WB-1:0] : rs[WB-1:0];
    n.nq    = {s.nq[NB-2:0], ge};
    return n;
  endfunction

  function automatic q_t dv_final(input dst_t s);
    logic [NB:0] q;
    q = {1'b0, s.nq} + NB'({s.rem, 1'b0} >= {1'b0, s.md});
    return s.dz ? s.spec : from_mag(s.neg, 64'(q));
  endfunction

  dst_t          st_r   [0:NB];
  logic [SW-1:0] side_r [0:NB];
  logic [NB+1:0] vld_r;
  q_t            quot_r;
  logic [SW-1:0] oside_r;
  dst_t          st0;

  always_comb begin
    st0.rem  = '0;
    st0.nq   = {mag(num), {FB{1'b0}}};
    st0.md   = mag(den);
    st0.neg  = num[WB-1] ^ den[WB-1];
    st0.dz   = (den == '0);
    st0.spec = (num == '0) ? '0 : (num[WB-1] ? Q_MIN : Q_MAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NB:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0]   <= st0;
      side_r[0] <= in_side;
      for (int k = 1; k <= NB; k++) begin
        st_r[k]   <= dv_step(st_r[k-1]);
        side_r[k] <= side_r[k-1];
      end
      quot_r  <= dv_final(st_r[NB]);
      oside_r <= side_r[NB];
    end
  end

  assign out_valid = vld_r[NB+1];
  assign quot      = quot_r;
  assign out_side  = oside_r;

endmodule
